// ----- hw/rtl/serial_to_chip_bus_bridge_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the serial to chip bus bridge
// Clocked, reset-gated concurrent assertion shorthands.
// ----------------------------------------------------------------------------
`ifndef SERIAL_TO_CHIP_BUS_BRIDGE_CORE_ASSERT_SVH
`define SERIAL_TO_CHIP_BUS_BRIDGE_CORE_ASSERT_SVH

// same-cycle implication
`define STCB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial bridge check failed");

// next-cycle implication
`define STCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serial bridge check failed");

`endif

// ----- hw/rtl/stcb_pkg.sv -----
// ----------------------------------------------------------------------------
// stcb_pkg
// Codes, constants and types of the serial to chip bus bridge.
// ----------------------------------------------------------------------------
`default_nettype none

package stcb_pkg;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_BYTE        = 2'd1,
    OP_FRAME_ERR   = 2'd2,
    OP_OVERRUN_ERR = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    EV_BUS_WRITE   = 2'd0,
    EV_RESET_PULSE = 2'd1,
    EV_REPLY       = 2'd2
  } event_e;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] IDLE_COUNT_RST   = 16'd2000;

  localparam logic [7:0] CMD_CHIP_RESET = 8'hFF;
  localparam logic [7:0] SEL_HI_MASK    = 8'hF0;
  localparam logic [7:0] SEL_LO_MASK    = 8'h0F;
  localparam logic [7:0] SEL_LOW_ZERO   = 8'h01;
  localparam logic [7:0] SEL_LOW_ONE    = 8'h05;
  localparam logic [7:0] SEL_LOW_MANY   = 8'h09;
  localparam logic [7:0] CTL_DATA_BITS  = 8'h03;
  localparam logic [7:0] CTL_RESET      = 8'h81;
  localparam logic [7:0] REPLY_O        = 8'h4F;
  localparam logic [7:0] REPLY_K        = 8'h4B;

  // one queued burst: a single bus write, or the reset pulse + "OK" reply
  typedef struct packed {
    logic       rst_burst;
    logic [7:0] data;
    logic [7:0] ctl;
  } burst_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stcb_if.sv -----
// ----------------------------------------------------------------------------
// stcb_in_if / stcb_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface stcb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface stcb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] bus_data;
  logic [7:0] control;
  logic [7:0] reply_byte;
  logic       last;

  modport source (output valid, output event_res, output bus_data, output control,
                  output reply_byte, output last, input ready);
  modport sink   (input valid, input event_res, input bus_data, input control,
                  input reply_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/serial_to_chip_bus_bridge_core.sv -----
// ----------------------------------------------------------------------------
// serial_to_chip_bus_bridge_core
// Turns received serial bytes and timer ticks into chip bus writes,
// chip reset pulses and serial reply bytes.
// ----------------------------------------------------------------------------
// The bridge takes one input transaction per clock. Phase state, select
// latch and idle timer update in the cycle the transaction is accepted;
// any results it causes go into a two-entry burst queue that feeds the
// output channel. An address or data byte gives one bus-write transaction;
// the chip reset command (0xFF in the command phase) gives three output
// transactions (reset pulse, 'O', 'K'). Ticks, error
// bytes and select bytes give nothing. Input ready drops only while both
// queue entries are occupied, so sustained throughput is one input per
// cycle as long as the sink takes results, limited only by the output
// port's one transaction per cycle during reset bursts. Configuration
// (idle timeout, 16 bits) is written through cfg_we_i/cfg_data_i.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_to_chip_bus_bridge_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  stcb_in_if.sink          in_i,
  stcb_out_if.source       out_o
);

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  // architectural state
  phase_e      phase_q, phase_d;
  logic [7:0]  sel_q, sel_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] timeout_q;

  // burst queue
  stcb_pkg::burst_t q_mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic [1:0]       idx_q;   // position inside a reset burst

  logic              in_acc, out_acc, push, pop;
  stcb_pkg::burst_t  push_entry, head;
  stcb_pkg::opcode_e op;
  logic [15:0]       idle_dec;
  logic [7:0]        low_nib;

  assign op      = stcb_pkg::opcode_e'(in_i.opcode);
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign idle_dec = idle_q - 16'd1;
  assign low_nib  = in_i.rx_byte & stcb_pkg::SEL_LO_MASK;

  // ---------------------------------------------------------------------------
  // Phase / timer update and burst generation
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d    = phase_q;
    sel_d      = sel_q;
    idle_d     = idle_q;
    push       = 1'b0;
    push_entry = '{rst_burst: 1'b0, data: in_i.rx_byte, ctl: sel_q};
    if (in_acc) begin
      unique case (op)
        stcb_pkg::OP_TICK: begin
          // idle timer expiry pulls the bridge back to command phase
          if (idle_dec == 16'd0) begin
            phase_d = PH_CMD;
            idle_d  = timeout_q;
          end else begin
            idle_d  = idle_dec;
          end
        end
        stcb_pkg::OP_BYTE: begin
          idle_d = timeout_q;
          case (phase_q)
            PH_ADDR: begin
              push    = 1'b1;   // address write, A0 low
              phase_d = PH_DATA;
            end
            PH_DATA: begin
              push           = 1'b1;   // data write, A0 and strobe bits set
              push_entry.ctl = sel_q | stcb_pkg::CTL_DATA_BITS;
              phase_d        = PH_CMD;
            end
            default: begin
              // command phase (the unused phase code behaves the same)
              if (in_i.rx_byte == stcb_pkg::CMD_CHIP_RESET) begin
                push                 = 1'b1;
                push_entry.rst_burst = 1'b1;
                phase_d              = PH_CMD;
              end else begin
                if (low_nib == 8'd0) begin
                  sel_d = (in_i.rx_byte & stcb_pkg::SEL_HI_MASK) | stcb_pkg::SEL_LOW_ZERO;
                end else if (low_nib == 8'd1) begin
                  sel_d = (in_i.rx_byte & stcb_pkg::SEL_HI_MASK) | stcb_pkg::SEL_LOW_ONE;
                end else begin
                  sel_d = (in_i.rx_byte & stcb_pkg::SEL_HI_MASK) | stcb_pkg::SEL_LOW_MANY;
                end
                phase_d = PH_ADDR;
              end
            end
          endcase
        end
        stcb_pkg::OP_FRAME_ERR, stcb_pkg::OP_OVERRUN_ERR: begin
          idle_d = timeout_q;   // byte dropped, link still counts as active
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: head of queue expanded into result transactions
  // ---------------------------------------------------------------------------
  assign head        = q_mem_q[rd_ptr_q];
  assign in_i.ready  = (cnt_q != 2'd2);
  assign out_o.valid = (cnt_q != 2'd0);

  always_comb begin
    out_o.event_res  = stcb_pkg::EV_BUS_WRITE;
    out_o.bus_data   = head.data;
    out_o.control    = head.ctl;
    out_o.reply_byte = 8'd0;
    out_o.last       = 1'b1;
    if (head.rst_burst) begin
      out_o.bus_data = 8'd0;
      out_o.control  = 8'd0;
      unique case (idx_q)
        2'd0: begin
          out_o.event_res = stcb_pkg::EV_RESET_PULSE;
          out_o.control   = stcb_pkg::CTL_RESET;
          out_o.last      = 1'b0;
        end
        2'd1: begin
          out_o.event_res  = stcb_pkg::EV_REPLY;
          out_o.reply_byte = stcb_pkg::REPLY_O;
          out_o.last       = 1'b0;
        end
        default: begin
          out_o.event_res  = stcb_pkg::EV_REPLY;
          out_o.reply_byte = stcb_pkg::REPLY_K;
        end
      endcase
    end
  end

  assign pop = out_acc && out_o.last;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CMD;
      sel_q     <= 8'd0;
      idle_q    <= stcb_pkg::IDLE_COUNT_RST;
      timeout_q <= stcb_pkg::IDLE_TIMEOUT_RST;
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      cnt_q     <= 2'd0;
      idx_q     <= 2'd0;
    end else begin
      phase_q <= phase_d;
      sel_q   <= sel_d;
      idle_q  <= idle_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
      if (out_acc) begin
        idx_q <= out_o.last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stcb_checker.sv -----
// ----------------------------------------------------------------------------
// stcb_checker
// Port-level checks on the result stream of the bridge, bound to the bridge core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_to_chip_bus_bridge_core_assert.svh"

module stcb_checker (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  stcb_in_if.sink    in_i,
  stcb_out_if.source out_o
);

  logic out_acc;
  logic is_rst, is_reply_o, is_reply_k, is_bus, rst_ctl;

  assign out_acc    = out_o.valid && out_o.ready;
  assign is_rst     = out_o.valid && (out_o.event_res == stcb_pkg::EV_RESET_PULSE);
  assign is_reply_o = out_o.valid && (out_o.event_res == stcb_pkg::EV_REPLY)
                      && (out_o.reply_byte == stcb_pkg::REPLY_O);
  assign is_reply_k = out_o.valid && (out_o.event_res == stcb_pkg::EV_REPLY)
                      && (out_o.reply_byte == stcb_pkg::REPLY_K);
  assign is_bus     = out_o.valid && (out_o.event_res == stcb_pkg::EV_BUS_WRITE);
  assign rst_ctl    = (out_o.control == stcb_pkg::CTL_RESET);

  // reset pulse is never the end of its burst and drives the reset control
  `STCB_ASSERT_IMPL(a_rst_shape, clk_i, rst_ni, is_rst, !out_o.last && rst_ctl)
  // 'O' follows a taken reset pulse at once
  `STCB_ASSERT_NEXT(a_rst_then_o, clk_i, rst_ni, out_acc && is_rst, is_reply_o && !out_o.last)
  // 'K' closes the burst right after 'O'
  `STCB_ASSERT_NEXT(a_o_then_k, clk_i, rst_ni, out_acc && is_reply_o, is_reply_k && out_o.last)
  // bus writes are single results
  `STCB_ASSERT_IMPL(a_bus_single, clk_i, rst_ni, is_bus, out_o.last && (out_o.reply_byte == 8'd0))
  // input never stalls while the output side is empty
  `STCB_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_o.valid, in_i.ready)

endmodule

bind serial_to_chip_bus_bridge_core stcb_checker u_stcb_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_i  (in_i),
  .out_o (out_o)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for serial_to_chip_bus_bridge_core. A directed table
// runs first, then random command/address/data sequences mixed with ticks,
// error bytes and reset commands. Results are checked in order against a
// built-in model of the phase logic, select latch and idle timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned SETTLE_CYCLES    = 8;    // covers queue depth
  localparam int unsigned LONG_HOLD        = 300;  // receiver back-pressure stretch
  localparam int unsigned DIRECTED_TIMEOUT = 12;   // short timeout for the table

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  // one output transaction, in port order
  typedef struct packed {
    stcb_pkg::event_e ev;
    logic [7:0]       data;
    logic [7:0]       ctl;
    logic [7:0]       rep;
    logic             last;
  } bus_res_t;

  // directed table row; tv holds hand-typed results when typed is set
  typedef struct packed {
    stcb_pkg::opcode_e op;
    logic [7:0]        rx;
    logic [15:0]       reps;
    logic              typed;
    logic [1:0]        ntyped;
    bus_res_t [2:0]    tv;
  } stim_row_t;

  localparam bus_res_t NO_RES    = '0;
  localparam bus_res_t R_PULSE   = {stcb_pkg::EV_RESET_PULSE, 8'h00, stcb_pkg::CTL_RESET,
                                    8'h00, 1'b0};
  localparam bus_res_t R_REPLY_O = {stcb_pkg::EV_REPLY, 8'h00, 8'h00, stcb_pkg::REPLY_O,
                                    1'b0};
  localparam bus_res_t R_REPLY_K = {stcb_pkg::EV_REPLY, 8'h00, 8'h00, stcb_pkg::REPLY_K,
                                    1'b1};
  // first select after reset is 0x00 -> latch 0x01
  localparam bus_res_t R_ADDR_00 = {stcb_pkg::EV_BUS_WRITE, 8'h00, stcb_pkg::SEL_LOW_ZERO,
                                    8'h00, 1'b1};
  localparam bus_res_t R_DATA_FF = {stcb_pkg::EV_BUS_WRITE, 8'hFF,
                                    stcb_pkg::SEL_LOW_ZERO | stcb_pkg::CTL_DATA_BITS,
                                    8'h00, 1'b1};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;

  stcb_in_if  byte_if ();
  stcb_out_if res_if ();

  serial_to_chip_bus_bridge_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (byte_if),
    .out_o      (res_if)
  );

  // --------------------------------------------------------------------------
  // Bridge model state: phase, select latch, idle timer and its reload value.
  // --------------------------------------------------------------------------
  phase_e      bus_phase;
  logic [7:0]  sel_latch;
  logic [15:0] idle_left;
  logic [15:0] idle_limit;

  bus_res_t    fresh [0:2];   // results of the latest accepted transaction
  bus_res_t    want_q [$];    // results still owed by the bridge
  stim_row_t   script_q [$];

  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bus_res_t mk_res(stcb_pkg::event_e ev, logic [7:0] d, logic [7:0] c,
                                      logic [7:0] r, logic l);
    mk_res.ev   = ev;
    mk_res.data = d;
    mk_res.ctl  = c;
    mk_res.rep  = r;
    mk_res.last = l;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom();
    rand_byte = r[7:0];
  endfunction

  // Advance the model by one accepted transaction; fills fresh[], returns count.
  function automatic int forecast(stcb_pkg::opcode_e op, logic [7:0] rx);
    int n;
    n = 0;
    case (op)
      stcb_pkg::OP_TICK: begin
        // timer wraps mod 2^16; expiry drops back to command phase
        idle_left = idle_left - 16'd1;
        if (idle_left == 16'd0) begin
          bus_phase = PH_CMD;
          idle_left = idle_limit;
        end
      end
      stcb_pkg::OP_BYTE: begin
        idle_left = idle_limit;
        case (bus_phase)
          PH_ADDR: begin
            // address write, A0 low
            fresh[0]  = mk_res(stcb_pkg::EV_BUS_WRITE, rx, sel_latch, 8'h00, 1'b1);
            n         = 1;
            bus_phase = PH_DATA;
          end
          PH_DATA: begin
            fresh[0]  = mk_res(stcb_pkg::EV_BUS_WRITE, rx,
                               sel_latch | stcb_pkg::CTL_DATA_BITS, 8'h00, 1'b1);
            n         = 1;
            bus_phase = PH_CMD;
          end
          default: begin
            // command phase; an unreachable phase 3 lands here as well
            if (rx == stcb_pkg::CMD_CHIP_RESET) begin
              fresh[0]  = mk_res(stcb_pkg::EV_RESET_PULSE, 8'h00, stcb_pkg::CTL_RESET,
                                 8'h00, 1'b0);
              fresh[1]  = mk_res(stcb_pkg::EV_REPLY, 8'h00, 8'h00, stcb_pkg::REPLY_O, 1'b0);
              fresh[2]  = mk_res(stcb_pkg::EV_REPLY, 8'h00, 8'h00, stcb_pkg::REPLY_K, 1'b1);
              n         = 3;
              bus_phase = PH_CMD;
            end else begin
              sel_latch = (rx & stcb_pkg::SEL_HI_MASK) |
                          (((rx & stcb_pkg::SEL_LO_MASK) == 8'h00) ? stcb_pkg::SEL_LOW_ZERO :
                           ((rx & stcb_pkg::SEL_LO_MASK) == 8'h01) ? stcb_pkg::SEL_LOW_ONE  :
                                                                     stcb_pkg::SEL_LOW_MANY);
              bus_phase = PH_ADDR;
            end
          end
        endcase
      end
      default: begin
        // framing/overrun: byte dropped, timer still reloads
        idle_left = idle_limit;
      end
    endcase
    forecast = n;
  endfunction

  function automatic void bank(int n);
    for (int k = 0; k < n; k++) want_q.push_back(fresh[k]);
  endfunction

  function automatic void add_row(stcb_pkg::opcode_e op, logic [7:0] rx, int unsigned reps,
                                  int unsigned typed, int unsigned ntyped,
                                  bus_res_t r0, bus_res_t r1, bus_res_t r2);
    stim_row_t row;
    row.op     = op;
    row.rx     = rx;
    row.reps   = 16'(reps);
    row.typed  = (typed != 0);
    row.ntyped = 2'(ntyped);
    row.tv[0]  = r0;
    row.tv[1]  = r1;
    row.tv[2]  = r2;
    script_q.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    mismatches++;
  endtask

  task automatic note_field(string name, logic [7:0] got, logic [7:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, exp_v));
  endtask

  // --------------------------------------------------------------------------
  // Input side. present() is entered on a rising edge and returns on the edge
  // where the transaction was taken (valid && ready sampled before the edge).
  // --------------------------------------------------------------------------
  task automatic present(stcb_pkg::opcode_e op, logic [7:0] rx);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid   <= 1'b1;
    byte_if.opcode  <= op;
    byte_if.rx_byte <= rx;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  task automatic send(stcb_pkg::opcode_e op, logic [7:0] rx);
    present(op, rx);
    bank(forecast(op, rx));
  endtask

  // Sender pause: drop valid and wait for every owed result, then let the
  // bridge settle (a select or tick may still be in flight with nothing owed).
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Timeout writes only with the bridge idle.
  task automatic write_timeout(logic [15:0] v);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    idle_limit  = v;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic stray_tick();
    if ($urandom_range(4) == 0) send(stcb_pkg::OP_TICK, rand_byte());
  endtask

  // A burst of ticks; short enough to expire small timeouts now and then.
  task automatic tick_burst();
    int unsigned span;
    span = (idle_limit < 16'd8) ? idle_limit + 1 : 8;
    repeat ($urandom_range(span, 1)) send(stcb_pkg::OP_TICK, rand_byte());
  endtask

  // Mostly well-formed select/address/data triples with random content, plus
  // reset commands, tick bursts, error bytes and lone bytes that break the
  // sequence. Only good bytes count toward n_bytes.
  task automatic random_phase(int unsigned n_bytes);
    int unsigned made;
    int unsigned pick;
    logic [7:0]  sel;
    made = 0;
    while (made < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        sel = rand_byte();
        case ($urandom_range(2))
          0: sel[3:0] = 4'h0;
          1: sel[3:0] = 4'h1;
          default: ;
        endcase
        stray_tick();
        send(stcb_pkg::OP_BYTE, sel);
        stray_tick();
        send(stcb_pkg::OP_BYTE, rand_byte());
        stray_tick();
        send(stcb_pkg::OP_BYTE, rand_byte());
        made += 3;
      end else if (pick < 68) begin
        send(stcb_pkg::OP_BYTE, stcb_pkg::CMD_CHIP_RESET);
        made++;
      end else if (pick < 80) begin
        tick_burst();
      end else if (pick < 90) begin
        send(pick[0] ? stcb_pkg::OP_FRAME_ERR : stcb_pkg::OP_OVERRUN_ERR, rand_byte());
      end else begin
        send(stcb_pkg::OP_BYTE, rand_byte());
        made++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready with random stalls, plus one long hold-off counted
  // here so the burst queue fills and the input stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : recv_proc
    int unsigned hold_left;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every taken transaction is matched with the oldest owed one.
  always @(posedge clk) begin : check_proc
    bus_res_t exp_r;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result ev %0d data 0x%02h ctl 0x%02h",
                                  res_if.event_res, res_if.bus_data, res_if.control));
      end else begin
        exp_r = want_q.pop_front();
        note_field("event_res",  {6'd0, res_if.event_res}, {6'd0, exp_r.ev});
        note_field("bus_data",   res_if.bus_data,          exp_r.data);
        note_field("control",    res_if.control,           exp_r.ctl);
        note_field("reply_byte", res_if.reply_byte,        exp_r.rep);
        note_field("last",       {7'd0, res_if.last},      {7'd0, exp_r.last});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    int        n;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    byte_if.valid   = 1'b0;
    byte_if.opcode  = stcb_pkg::OP_TICK;
    byte_if.rx_byte = '0;
    hold_req        = 1'b0;
    mismatches      = 0;
    cycle_cnt       = 0;
    set_idling(0, 0);

    bus_phase  = PH_CMD;
    sel_latch  = '0;
    idle_left  = stcb_pkg::IDLE_COUNT_RST;
    idle_limit = stcb_pkg::IDLE_TIMEOUT_RST;

    // Directed table. Typed rows carry results read straight off the spec;
    // the rest go through the model.
    add_row(stcb_pkg::OP_BYTE, stcb_pkg::CMD_CHIP_RESET, 1, 1, 3,
            R_PULSE, R_REPLY_O, R_REPLY_K);
    add_row(stcb_pkg::OP_FRAME_ERR,   8'hFF, 1, 1, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_OVERRUN_ERR, 8'h00, 1, 1, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h00, 1, 1, 0, NO_RES, NO_RES, NO_RES);  // select, nibble 0
    add_row(stcb_pkg::OP_BYTE, 8'h00, 1, 1, 1, R_ADDR_00, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'hFF, 1, 1, 1, R_DATA_FF, NO_RES, NO_RES);  // data, not cmd
    add_row(stcb_pkg::OP_BYTE, 8'hF1, 1, 0, 0, NO_RES, NO_RES, NO_RES);  // select, nibble 1
    add_row(stcb_pkg::OP_FRAME_ERR,   8'h5A, 1, 0, 0, NO_RES, NO_RES, NO_RES);  // dropped
    add_row(stcb_pkg::OP_BYTE, 8'hA5, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_OVERRUN_ERR, 8'hA5, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h5A, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'hFE, 1, 0, 0, NO_RES, NO_RES, NO_RES);  // select, many
    add_row(stcb_pkg::OP_TICK, 8'hFF, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h80, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h7F, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    // one tick short of the timeout: sequence survives
    add_row(stcb_pkg::OP_BYTE, 8'h12, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_TICK, 8'h00, DIRECTED_TIMEOUT - 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h34, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h56, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    // full timeout: back to command phase, next 0xFF is a reset command
    add_row(stcb_pkg::OP_BYTE, 8'h20, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_TICK, 8'h00, DIRECTED_TIMEOUT, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, stcb_pkg::CMD_CHIP_RESET, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h0F, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'h01, 1, 0, 0, NO_RES, NO_RES, NO_RES);
    add_row(stcb_pkg::OP_BYTE, 8'hFF, 1, 0, 0, NO_RES, NO_RES, NO_RES);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short timeout keeps the expiry rows brief
    write_timeout(16'(DIRECTED_TIMEOUT));

    for (int i = 0; i < script_q.size(); i++) begin
      row = script_q[i];
      repeat (row.reps) begin
        present(row.op, row.rx);
        n = forecast(row.op, row.rx);
        if (row.typed) begin
          n = int'(row.ntyped);
          for (int k = 0; k < 3; k++) fresh[k] = row.tv[k];
        end
        bank(n);
      end
    end

    // Random phases across timeout settings and idling mixes.
    write_timeout(16'd1);      // every tick expires once the timer has reloaded
    set_idling(0, 0);
    random_phase(30);

    write_timeout(16'hFFFF);
    set_idling(61, 0);
    random_phase(25);

    write_timeout(16'd3);
    set_idling(0, 61);
    random_phase(30);

    write_timeout(16'd5);
    set_idling(14, 14);
    random_phase(30);

    write_timeout(16'($urandom_range(12, 2)));
    set_idling(0, 0);
    random_phase(25);

    // Back-pressure: receiver holds off while reset commands keep coming, so
    // the burst queue fills and the input stalls; then drain completely.
    write_timeout(stcb_pkg::IDLE_TIMEOUT_RST);
    set_idling(0, 0);
    hold_req = 1'b1;
    repeat (12) send(stcb_pkg::OP_BYTE, stcb_pkg::CMD_CHIP_RESET);
    wait_drained();

    set_idling(61, 61);
    random_phase(30);

    wait_drained();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
